FILE: design/mass_action_rate_eval_macros.svh
// Assertion macros shared by the checker of the mass-action rate block.
// Depends on nothing; taken in by the checker file.
`ifndef MASS_ACTION_RATE_EVAL_MACROS_SVH
`define MASS_ACTION_RATE_EVAL_MACROS_SVH

// ante in this cycle implies cons in the same cycle
`define MARE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante in this cycle implies cons in the next cycle
`define MARE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// expr never holds outside reset
`define MARE_ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

FILE: design/mare_pkg.sv
// Package of the mass-action rate block: widths, beat types, microcode table.
// Depends on nothing; used by the interfaces, the top level and the checker.
package mare_pkg;

  localparam int NUM_SPECIES = 8;
  localparam int ORDER_BITS  = 4;
  localparam int CONC_W      = 32;
  localparam int ACC_W       = 48;
  localparam int SPC_W       = 3;
  localparam int PC_W        = 3;
  localparam int PROD_W      = 2 * CONC_W;

  localparam logic [SPC_W-1:0] SPC_LAST = SPC_W'(NUM_SPECIES - 1);

  localparam logic [PROD_W-1:0] ROUND_HALF  = PROD_W'(64'h8000);
  localparam logic [PROD_W-1:0] MAG_MAX_POS = PROD_W'(64'h7FFF_FFFF_FFFF);
  localparam logic [PROD_W-1:0] MAG_MAX_NEG = PROD_W'(64'h8000_0000_0000);

  localparam logic [0:0] REG_ORDERS = 1'b0;
  localparam logic [0:0] REG_CLAMP  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] rate_coef;
    logic [2:0]  deriv_species;
    logic signed [31:0] conc_0;
    logic signed [31:0] conc_1;
    logic signed [31:0] conc_2;
    logic signed [31:0] conc_3;
    logic signed [31:0] conc_4;
    logic signed [31:0] conc_5;
    logic signed [31:0] conc_6;
    logic signed [31:0] conc_7;
  } in_beat_t;

  typedef struct packed {
    logic signed [47:0] rate_value;
    logic               overflow;
  } out_beat_t;

  typedef enum logic [2:0] {
    UOP_WAIT,
    UOP_CHECK,
    UOP_SETUP,
    UOP_MLO,
    UOP_MHI,
    UOP_ACC,
    UOP_NEXT,
    UOP_OUT
  } uop_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_NO_IN,
    COND_SKIP,
    COND_CNT_ZERO,
    COND_CNT_MORE,
    COND_NOT_LAST,
    COND_NO_OUT
  } cond_t;

  typedef struct packed {
    uop_t            uop;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  localparam logic [PC_W-1:0] PC_WAIT  = 3'd0;
  localparam logic [PC_W-1:0] PC_CHECK = 3'd1;
  localparam logic [PC_W-1:0] PC_SETUP = 3'd2;
  localparam logic [PC_W-1:0] PC_MLO   = 3'd3;
  localparam logic [PC_W-1:0] PC_MHI   = 3'd4;
  localparam logic [PC_W-1:0] PC_ACC   = 3'd5;
  localparam logic [PC_W-1:0] PC_NEXT  = 3'd6;
  localparam logic [PC_W-1:0] PC_OUT   = 3'd7;

  // taken jump goes to target, otherwise fall through to pc + 1
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t cw;
    unique case (pc)
      PC_WAIT:  cw = '{uop: UOP_WAIT,  cond: COND_NO_IN,    target: PC_WAIT};
      PC_CHECK: cw = '{uop: UOP_CHECK, cond: COND_SKIP,     target: PC_OUT};
      PC_SETUP: cw = '{uop: UOP_SETUP, cond: COND_NONE,     target: PC_WAIT};
      PC_MLO:   cw = '{uop: UOP_MLO,   cond: COND_CNT_ZERO, target: PC_NEXT};
      PC_MHI:   cw = '{uop: UOP_MHI,   cond: COND_NONE,     target: PC_WAIT};
      PC_ACC:   cw = '{uop: UOP_ACC,   cond: COND_CNT_MORE, target: PC_MLO};
      PC_NEXT:  cw = '{uop: UOP_NEXT,  cond: COND_NOT_LAST, target: PC_SETUP};
      PC_OUT:   cw = '{uop: UOP_OUT,   cond: COND_NO_OUT,   target: PC_OUT};
      default:  cw = '{uop: UOP_WAIT,  cond: COND_NONE,     target: PC_WAIT};
    endcase
    return cw;
  endfunction

endpackage

FILE: design/mare_in_if.sv
// Input channel of the mass-action rate block: valid, ready and one item.
// Depends on mare_pkg.
interface mare_in_if;
  logic                valid;
  logic                ready;
  mare_pkg::in_beat_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/mare_out_if.sv
// Output channel of the mass-action rate block: valid, ready and one result.
// Depends on mare_pkg.
interface mare_out_if;
  logic                valid;
  logic                ready;
  mare_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/mass_action_rate_eval.sv
// Mass-action rate evaluator: one item at a time, run by an eight-step
// microprogram over a single shared 32x32 multiplier. Every Q32.16 by Q16.16
// multiply takes three steps (low partial product, high partial product,
// round and saturate). A derivative request on a species of order zero
// returns zero without running the multiplies. The next input beat is taken
// the cycle after the result beat. Configuration writes are registered.
// Depends on mare_pkg, mare_in_if and mare_out_if.
module mass_action_rate_eval (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [31:0]                   cfg_data,
  mare_in_if.sink                       in_ch,
  mare_out_if.source                    out_ch
);

  logic [mare_pkg::PC_W-1:0]       pc;
  logic [mare_pkg::PC_W-1:0]       pc_next;
  mare_pkg::ctrl_t                 cw;
  logic                            taken;

  logic [31:0]                     ords;
  logic                            clamp;

  logic                            deriv;
  logic [mare_pkg::SPC_W-1:0]      dspec;
  logic [mare_pkg::CONC_W-1:0]     conc_arr [mare_pkg::NUM_SPECIES];
  logic [mare_pkg::SPC_W-1:0]      spc;
  logic [mare_pkg::ORDER_BITS-1:0] cnt;

  logic                            sa;
  logic [mare_pkg::ACC_W-1:0]      ma;
  logic                            ovf;
  logic                            op_sign;
  logic [mare_pkg::CONC_W-1:0]     op_mag;
  logic [mare_pkg::PROD_W-1:0]     lo;
  logic [mare_pkg::ACC_W-1:0]      hi;

  logic                            in_beat;
  logic                            out_beat;
  logic [mare_pkg::ORDER_BITS-1:0] cur_order;
  logic [mare_pkg::ORDER_BITS-1:0] d_order;
  logic                            skip;
  logic [mare_pkg::CONC_W-1:0]     raw;
  logic                            c_sign;
  logic [mare_pkg::CONC_W-1:0]     c_mag;
  logic [mare_pkg::CONC_W-1:0]     mul_a;
  logic [mare_pkg::PROD_W-1:0]     prod;
  logic [mare_pkg::PROD_W-1:0]     q;
  logic                            q_neg;
  logic [mare_pkg::PROD_W-1:0]     q_sat;
  logic                            q_ovf;

  assign cw       = mare_pkg::ucode(pc);
  assign in_ch.ready  = (cw.uop == mare_pkg::UOP_WAIT);
  assign out_ch.valid = (cw.uop == mare_pkg::UOP_OUT);
  assign in_beat  = in_ch.valid && in_ch.ready;
  assign out_beat = out_ch.valid && out_ch.ready;

  assign out_ch.data.rate_value = sa ? (~ma + 1'b1) : ma;
  assign out_ch.data.overflow   = ovf;

  assign cur_order = ords[spc * mare_pkg::ORDER_BITS +: mare_pkg::ORDER_BITS];
  assign d_order   = ords[dspec * mare_pkg::ORDER_BITS +: mare_pkg::ORDER_BITS];
  assign skip = deriv && (({1'b0, dspec} >= (mare_pkg::SPC_W + 1)'(mare_pkg::NUM_SPECIES))
                          || (d_order == '0));

  always_comb begin
    raw    = conc_arr[spc];
    c_sign = raw[mare_pkg::CONC_W-1];
    c_mag  = c_sign ? (~raw + 1'b1) : raw;
    if (c_sign && clamp) begin
      c_sign = 1'b0;
      c_mag  = '0;
    end
  end

  assign mul_a = (cw.uop == mare_pkg::UOP_MHI)
               ? {16'b0, ma[mare_pkg::ACC_W-1:mare_pkg::CONC_W]}
               : ma[mare_pkg::CONC_W-1:0];
  assign prod  = {32'b0, mul_a} * {32'b0, op_mag};

  always_comb begin
    q     = ({16'b0, hi} << 16) + {16'b0, lo[mare_pkg::PROD_W-1:16]};
    q_neg = sa ^ op_sign;
    q_sat = q;
    q_ovf = 1'b0;
    if (!q_neg && (q > mare_pkg::MAG_MAX_POS)) begin
      q_sat = mare_pkg::MAG_MAX_POS;
      q_ovf = 1'b1;
    end else if (q_neg && (q > mare_pkg::MAG_MAX_NEG)) begin
      q_sat = mare_pkg::MAG_MAX_NEG;
      q_ovf = 1'b1;
    end
    if (q_sat == '0) begin
      q_neg = 1'b0;
    end
  end

  always_comb begin
    unique case (cw.cond)
      mare_pkg::COND_NONE:     taken = 1'b0;
      mare_pkg::COND_NO_IN:    taken = !in_beat;
      mare_pkg::COND_SKIP:     taken = skip;
      mare_pkg::COND_CNT_ZERO: taken = (cnt == '0);
      mare_pkg::COND_CNT_MORE: taken = (cnt > mare_pkg::ORDER_BITS'(1));
      mare_pkg::COND_NOT_LAST: taken = (spc != mare_pkg::SPC_LAST);
      mare_pkg::COND_NO_OUT:   taken = !out_beat;
      default:                 taken = 1'b0;
    endcase
    pc_next = taken ? cw.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= mare_pkg::PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ords  <= '0;
      clamp <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mare_pkg::REG_ORDERS: ords  <= cfg_data;
        mare_pkg::REG_CLAMP:  clamp <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cw.uop)
      mare_pkg::UOP_WAIT: begin
        if (in_beat) begin
          deriv       <= in_ch.data.req_type;
          dspec       <= in_ch.data.deriv_species;
          conc_arr[0] <= in_ch.data.conc_0;
          conc_arr[1] <= in_ch.data.conc_1;
          conc_arr[2] <= in_ch.data.conc_2;
          conc_arr[3] <= in_ch.data.conc_3;
          conc_arr[4] <= in_ch.data.conc_4;
          conc_arr[5] <= in_ch.data.conc_5;
          conc_arr[6] <= in_ch.data.conc_6;
          conc_arr[7] <= in_ch.data.conc_7;
          ma          <= {16'b0, in_ch.data.rate_coef};
          sa          <= 1'b0;
          ovf         <= 1'b0;
          spc         <= '0;
        end
      end
      mare_pkg::UOP_CHECK: begin
        if (skip) begin
          ma  <= '0;
          sa  <= 1'b0;
          ovf <= 1'b0;
        end
      end
      mare_pkg::UOP_SETUP: begin
        cnt <= cur_order;
        if (deriv && (spc == dspec)) begin
          op_sign <= 1'b0;
          op_mag  <= {12'b0, cur_order, 16'b0};
        end else begin
          op_sign <= c_sign;
          op_mag  <= c_mag;
        end
      end
      mare_pkg::UOP_MLO: begin
        lo <= prod + mare_pkg::ROUND_HALF;
      end
      mare_pkg::UOP_MHI: begin
        hi <= prod[mare_pkg::ACC_W-1:0];
      end
      mare_pkg::UOP_ACC: begin
        sa      <= q_neg;
        ma      <= q_sat[mare_pkg::ACC_W-1:0];
        ovf     <= ovf | q_ovf;
        cnt     <= cnt - 1'b1;
        op_sign <= c_sign;
        op_mag  <= c_mag;
      end
      mare_pkg::UOP_NEXT: begin
        spc <= spc + 1'b1;
      end
      mare_pkg::UOP_OUT: ;
      default: ;
    endcase
  end

endmodule

FILE: design/mare_checker.sv
// Port-level checker of the mass-action rate block and its bind.
// Depends on mare_pkg and mass_action_rate_eval_macros.svh.
`include "mass_action_rate_eval_macros.svh"

module mare_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mare_pkg::out_beat_t out_data
);

  `MARE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result beat dropped or changed while stalled")
  `MARE_ASSERT_NEVER(a_one_item, clk, rst, in_ready && out_valid, "input taken while a result waits")
  `MARE_ASSERT_NEXT(a_no_instant, clk, rst, in_valid && in_ready, !out_valid, "result shown the cycle after its input beat")
  `MARE_ASSERT_NEXT(a_one_result, clk, rst, out_valid && out_ready, !out_valid && in_ready, "result repeated or input not reopened")

endmodule

bind mass_action_rate_eval mare_checker u_mare_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
